[rtl/core/hsg_pkg.sv]
// hourglass sand grid package: types, codes, microcode rom and grid tables
// no dependencies; imported by every other file of the block but hsg_ram

package hsg_pkg;

  localparam int ROW_W     = 4;
  localparam int COL_W     = 3;
  localparam int CELLS_W   = 8;
  localparam int SAMPLE_W  = 10;
  localparam int NUM_ROWS  = 16;
  localparam int UPC_W     = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_DOWN_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UP_THR   = 1'b1;

  localparam logic [SAMPLE_W-1:0] DOWN_THR_RST = 10'd535;
  localparam logic [SAMPLE_W-1:0] UP_THR_RST   = 10'd380;

  typedef enum logic [1:0] {
    ORIENT_DOWN = 2'd0,
    ORIENT_UP   = 2'd1,
    ORIENT_FLAT = 2'd2
  } orient_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_NOP,
    OP_RD_ROWS,
    OP_LOAD,
    OP_CELL,
    OP_WR_SRC,
    OP_WR_DST,
    OP_FILL,
    OP_RD_REP,
    OP_OUT_LOAD
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_RESTART,
    C_FLAT,
    C_COL_MORE,
    C_ROW_MORE,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t op;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic restart;
    logic flat;
    logic col_more;
    logic row_more;
    logic out_full;
  } stat_t;

  // microcode entry points
  localparam logic [UPC_W-1:0] UA_IDLE = 4'd0;
  localparam logic [UPC_W-1:0] UA_ROW  = 4'd3;
  localparam logic [UPC_W-1:0] UA_CELL = 4'd5;
  localparam logic [UPC_W-1:0] UA_FILL = 4'd9;
  localparam logic [UPC_W-1:0] UA_REP  = 4'd10;

  function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: UA_IDLE};
    case (upc)
      4'd0:    w = '{op: OP_IDLE,     cond: C_NO_INPUT, target: UA_IDLE};
      4'd1:    w = '{op: OP_NOP,      cond: C_RESTART,  target: UA_FILL};
      4'd2:    w = '{op: OP_NOP,      cond: C_FLAT,     target: UA_REP};
      4'd3:    w = '{op: OP_RD_ROWS,  cond: C_NEVER,    target: UA_IDLE};
      4'd4:    w = '{op: OP_LOAD,     cond: C_NEVER,    target: UA_IDLE};
      4'd5:    w = '{op: OP_CELL,     cond: C_COL_MORE, target: UA_CELL};
      4'd6:    w = '{op: OP_WR_SRC,   cond: C_NEVER,    target: UA_IDLE};
      4'd7:    w = '{op: OP_WR_DST,   cond: C_ROW_MORE, target: UA_ROW};
      4'd8:    w = '{op: OP_NOP,      cond: C_ALWAYS,   target: UA_REP};
      4'd9:    w = '{op: OP_FILL,     cond: C_ROW_MORE, target: UA_FILL};
      4'd10:   w = '{op: OP_RD_REP,   cond: C_OUT_FULL, target: UA_REP};
      4'd11:   w = '{op: OP_OUT_LOAD, cond: C_ROW_MORE, target: UA_REP};
      default: w = '{op: OP_NOP,      cond: C_ALWAYS,   target: UA_IDLE};
    endcase
    return w;
  endfunction

  // fixed hourglass outline
  function automatic logic [CELLS_W-1:0] wall_row(input logic [ROW_W-1:0] r);
    logic [CELLS_W-1:0] m;
    m = 8'h00;
    case (r) inside
      4'd5, 4'd10: m = 8'h81;
      4'd6, 4'd9:  m = 8'hC3;
      4'd7, 4'd8:  m = 8'hE7;
      default:     m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [CELLS_W-1:0] fill_row(input orient_t o,
                                                  input logic [ROW_W-1:0] r);
    logic [CELLS_W-1:0] v;
    v = 8'h00;
    if (o == ORIENT_DOWN && r <= 4'd6) v = 8'hFF;
    else if (o == ORIENT_UP && r >= 4'd9) v = 8'hFF;
    return v & ~wall_row(r);
  endfunction

endpackage

[rtl/core/hsg_if.sv]
// channel interfaces of the hourglass sand grid: tick input, row report, config writes
// depends on hsg_pkg for field widths

interface hsg_in_if import hsg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] tilt_sample;
  logic                restart;
  modport source (output valid, output tilt_sample, output restart, input ready);
  modport sink   (input valid, input tilt_sample, input restart, output ready);
endinterface

interface hsg_out_if import hsg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   row_number;
  logic [CELLS_W-1:0] row_cells;
  logic [1:0]         orientation;
  logic               last_row;
  modport source (output valid, output row_number, output row_cells,
                  output orientation, output last_row, input ready);
  modport sink   (input valid, input row_number, input row_cells,
                  input orientation, input last_row, output ready);
endinterface

interface hsg_cfg_if import hsg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SAMPLE_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/hsg_ram.sv]
// generic ram: one write port, two read ports with registered read data
// no dependencies

module hsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[rtl/core/hsg_useq.sv]
// microcode sequencer: step counter, control rom lookup and conditional jumps
// depends on hsg_pkg

module hsg_useq import hsg_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  uword_t           uw;
  logic             take;

  assign uw      = ucode(upc_r);
  assign ctrl.op = uw.op;

  always_comb begin
    case (uw.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_INPUT: take = !stat.in_valid;
      C_RESTART:  take = stat.restart;
      C_FLAT:     take = stat.flat;
      C_COL_MORE: take = stat.col_more;
      C_ROW_MORE: take = stat.row_more;
      C_OUT_FULL: take = stat.out_full;
      default:    take = 1'b1;
    endcase
    upc_nxt = take ? uw.target : upc_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) upc_r <= UA_IDLE;
    else        upc_r <= upc_nxt;
  end

`ifndef NO_ASSERTIONS
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    upc_r <= 4'd12) else $error("step counter left the program");
`endif

endmodule

[rtl/core/hsg_dpath.sv]
// grid datapath: row ram, working rows, scan counters, move logic, report register
// depends on hsg_pkg, hsg_if and hsg_ram

module hsg_dpath import hsg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_t               ctrl,
  output stat_t               stat,
  input  logic [SAMPLE_W-1:0] down_thr,
  input  logic [SAMPLE_W-1:0] up_thr,
  hsg_in_if.sink              in_ch,
  hsg_out_if.source           out_ch
);

  orient_t            orient_r;
  logic               restart_r;
  logic [ROW_W-1:0]   k_r;
  logic [COL_W-1:0]   col_r;
  logic [CELLS_W-1:0] src_r, dst_r;
  logic [NUM_ROWS-1:0] valid_r;
  logic               va_r, vb_r;
  logic               out_valid_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [CELLS_W-1:0] out_cells_r;
  orient_t            out_orient_r;
  logic               out_last_r;

  logic               down, accept;
  orient_t            orient_in;
  logic [ROW_W-1:0]   row, tgt, raddr_a, waddr;
  logic               tgt_in, we;
  logic [CELLS_W-1:0] wdata, rd_a, rd_b, blocked, rd_a_m, rd_b_m;
  logic [COL_W-1:0]   c;
  logic               free_s, free_l, free_r;

  assign accept = (ctrl.op == OP_IDLE) && in_ch.valid;
  assign in_ch.ready = (ctrl.op == OP_IDLE);

  // down test first, so crossed thresholds read as down
  always_comb begin
    if (in_ch.tilt_sample > down_thr)    orient_in = ORIENT_DOWN;
    else if (in_ch.tilt_sample < up_thr) orient_in = ORIENT_UP;
    else                                 orient_in = ORIENT_FLAT;
  end

  assign down   = (orient_r == ORIENT_DOWN);
  assign row    = down ? ~k_r : k_r;
  assign tgt    = down ? row + 4'd1 : row - 4'd1;
  assign tgt_in = down ? (row != 4'd15) : (row != 4'd0);
  assign c      = down ? ~col_r : col_r;

  assign rd_a_m = va_r ? rd_a : '0;
  assign rd_b_m = vb_r ? rd_b : '0;

  assign blocked = dst_r | wall_row(tgt);
  assign free_s  = !blocked[c];
  assign free_l  = (c != 3'd0) && !blocked[c - 3'd1];
  assign free_r  = (c != 3'd7) && !blocked[c + 3'd1];

  // ram port selection
  always_comb begin
    raddr_a = (ctrl.op == OP_RD_REP) ? k_r : row;
    we      = 1'b0;
    waddr   = row;
    wdata   = src_r;
    case (ctrl.op)
      OP_WR_SRC: begin
        we = 1'b1;
      end
      OP_WR_DST: begin
        we    = tgt_in;
        waddr = tgt;
        wdata = dst_r;
      end
      OP_FILL: begin
        we    = 1'b1;
        waddr = k_r;
        wdata = fill_row(orient_r, k_r);
      end
      default: we = 1'b0;
    endcase
  end

  hsg_ram #(.WIDTH(CELLS_W), .DEPTH(NUM_ROWS)) u_grid (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (tgt),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      orient_r    <= ORIENT_FLAT;
      restart_r   <= 1'b0;
      k_r         <= '0;
      col_r       <= '0;
    end else begin
      if (we) valid_r[waddr] <= 1'b1;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      case (ctrl.op)
        OP_IDLE: begin
          if (accept) begin
            orient_r  <= orient_in;
            restart_r <= in_ch.restart;
            k_r       <= '0;
            col_r     <= '0;
          end
        end
        OP_LOAD:     col_r <= '0;
        OP_CELL:     col_r <= col_r + 3'd1;
        OP_WR_DST:   k_r   <= k_r + 4'd1;
        OP_FILL:     k_r   <= k_r + 4'd1;
        OP_OUT_LOAD: begin
          k_r         <= k_r + 4'd1;
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    va_r <= valid_r[raddr_a];
    vb_r <= valid_r[tgt];
    case (ctrl.op)
      OP_LOAD: begin
        src_r <= rd_a_m;
        dst_r <= tgt_in ? rd_b_m : 8'hFF;
      end
      OP_CELL: begin
        if (src_r[c]) begin
          if (free_s) begin
            dst_r[c] <= 1'b1;
            src_r[c] <= 1'b0;
          end else if (free_l) begin
            dst_r[c - 3'd1] <= 1'b1;
            src_r[c]        <= 1'b0;
          end else if (free_r) begin
            dst_r[c + 3'd1] <= 1'b1;
            src_r[c]        <= 1'b0;
          end
        end
      end
      OP_OUT_LOAD: begin
        out_row_r    <= k_r;
        out_cells_r  <= rd_a_m;
        out_orient_r <= orient_r;
        out_last_r   <= (k_r == 4'd15);
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.row_number  = out_row_r;
  assign out_ch.row_cells   = out_cells_r;
  assign out_ch.orientation = out_orient_r;
  assign out_ch.last_row    = out_last_r;

  assign stat.in_valid = in_ch.valid;
  assign stat.restart  = restart_r;
  assign stat.flat     = (orient_r == ORIENT_FLAT);
  assign stat.col_more = (col_r != 3'd7);
  assign stat.row_more = (k_r != 4'd15);
  assign stat.out_full = out_valid_r && !out_ch.ready;

`ifndef NO_ASSERTIONS
  a_no_wall_grain: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_WR_DST && tgt_in) |-> ((dst_r & wall_row(tgt)) == '0))
    else $error("grain written onto a wall cell");

  a_grains_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_CELL) |=>
      ($countones(src_r) + $countones(dst_r)) ==
      ($countones($past(src_r)) + $countones($past(dst_r))))
    else $error("cell step lost or made a grain");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_OUT_LOAD) |-> !out_valid_r)
    else $error("report word overwritten");
`endif

endmodule

[rtl/core/hourglass_sand_grid_step.sv]
// top level of the hourglass sand grid: config registers, sequencer and datapath
// depends on hsg_pkg, hsg_if, hsg_useq and hsg_dpath

// usage
//  in_ch takes one tick word: tilt_sample and restart; it is ready only while the
//  sequencer sits in its idle step, so one tick is handled at a time
//  out_ch then gives 16 words, rows 0 to 15 in order, last_row set on row 15,
//  each with the orientation found for that tick
//  cfg_ch writes down_threshold (index 0) or up_threshold (index 1); always ready,
//  meant to be used between ticks
//  passes: a move pass runs 16 rows of 12 microcode steps (row read, load,
//  8 column steps, two write-backs), a restart refills every row, a flat tick
//  moves nothing; the report then reads each row through the single registered
//  ram read in front of the output register
//  the next tick is taken while the last row still waits in the output register
//  reset: grid reads empty (row valid bits cleared), thresholds 535 and 380,
//  sequencer back at its idle step, no row pending
//  a stalled receiver holds the current row word and freezes the report walk

module hourglass_sand_grid_step import hsg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  hsg_in_if.sink     in_ch,
  hsg_out_if.source  out_ch,
  hsg_cfg_if.sink    cfg_ch
);

  // threshold registers
  logic [SAMPLE_W-1:0] down_thr_r;
  logic [SAMPLE_W-1:0] up_thr_r;

  // control word and status between sequencer and datapath
  ctrl_t ctrl;
  stat_t stat;

  // config writes are never stalled
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_thr_r <= DOWN_THR_RST;
      up_thr_r   <= UP_THR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DOWN_THR: down_thr_r <= cfg_ch.data;
        REG_UP_THR:   up_thr_r   <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // microcode sequencer: step counter and jumps
  hsg_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // grid ram, working rows and report register
  hsg_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .stat     (stat),
    .down_thr (down_thr_r),
    .up_thr   (up_thr_r),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule

[verif/hourglass_grid_checker.sv]
// checker for the hourglass sand grid: watches tick, row report and config words,
// keeps its own copy of the grid and thresholds and compares every row word
// depends on hsg_pkg and the channel interfaces in hsg_if

module hourglass_grid_checker import hsg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  hsg_in_if    in_mon,
  hsg_out_if   out_mon,
  hsg_cfg_if   cfg_mon,
  output int   mismatch_count,
  output int   rows_outstanding
);

  typedef struct {
    logic [ROW_W-1:0]   row;
    logic [CELLS_W-1:0] cells;
    orient_t            orient;
    logic               last;
  } row_report_t;

  // hourglass outline, bit n is column n
  localparam logic [CELLS_W-1:0] HOURGLASS_WALL [NUM_ROWS] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h81, 8'hC3, 8'hE7,
    8'hE7, 8'hC3, 8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  logic [CELLS_W-1:0]  sand_rows [NUM_ROWS];
  logic [SAMPLE_W-1:0] down_thr;
  logic [SAMPLE_W-1:0] up_thr;
  row_report_t         expected_rows [$];
  int                  ticks_seen;

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("mismatch on %s after tick %0d: got %0d, expected %0d",
               what, ticks_seen, got, want);
  endtask

  task automatic predict_tick(input logic [SAMPLE_W-1:0] tilt, input logic restart);
    orient_t     dir;
    int          row, col, nrow, ncol, k, r, t;
    int          step_col [3];
    bit          moved;
    row_report_t rep;
    step_col = '{0, -1, 1};
    if (tilt > down_thr) dir = ORIENT_DOWN;
    else if (tilt < up_thr) dir = ORIENT_UP;
    else dir = ORIENT_FLAT;

    if (restart) begin
      for (r = 0; r < NUM_ROWS; r++)
        sand_rows[r] = ((dir == ORIENT_DOWN && r <= 6) || (dir == ORIENT_UP && r >= 9)) ?
                       ~HOURGLASS_WALL[r] : 8'h00;
    end else if (dir != ORIENT_FLAT) begin
      // in-place pass from the gravity end, straight then lower then higher column
      for (k = 0; k < NUM_ROWS * 8; k++) begin
        if (dir == ORIENT_DOWN) begin
          row  = NUM_ROWS - 1 - k / 8;
          col  = 7 - k % 8;
          nrow = row + 1;
        end else begin
          row  = k / 8;
          col  = k % 8;
          nrow = row - 1;
        end
        moved = 1'b0;
        if (sand_rows[row][col] && nrow >= 0 && nrow < NUM_ROWS) begin
          for (t = 0; t < 3; t++) begin
            ncol = col + step_col[t];
            if (!moved && ncol >= 0 && ncol < 8 && !sand_rows[nrow][ncol] &&
                !HOURGLASS_WALL[nrow][ncol]) begin
              sand_rows[nrow][ncol] = 1'b1;
              sand_rows[row][col]   = 1'b0;
              moved = 1'b1;
            end
          end
        end
      end
    end

    for (r = 0; r < NUM_ROWS; r++) begin
      rep.row    = r[ROW_W-1:0];
      rep.cells  = sand_rows[r];
      rep.orient = dir;
      rep.last   = (r == NUM_ROWS - 1);
      expected_rows.push_back(rep);
    end
  endtask

  task automatic check_row_word();
    row_report_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch("row word with nothing pending", out_mon.row_number, -1);
    end else begin
      want = expected_rows.pop_front();
      if (out_mon.row_number !== want.row)
        report_mismatch("row_number", out_mon.row_number, want.row);
      if (out_mon.row_cells !== want.cells)
        report_mismatch("row_cells", out_mon.row_cells, want.cells);
      if (out_mon.orientation !== want.orient)
        report_mismatch("orientation", out_mon.orientation, want.orient);
      if (out_mon.last_row !== want.last)
        report_mismatch("last_row", out_mon.last_row, want.last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (sand_rows[r]) sand_rows[r] = '0;
      down_thr = DOWN_THR_RST;
      up_thr   = UP_THR_RST;
      expected_rows.delete();
      mismatch_count   = 0;
      rows_outstanding = 0;
      ticks_seen       = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_DOWN_THR: down_thr = cfg_mon.data;
          REG_UP_THR:   up_thr   = cfg_mon.data;
          default:      ;
        endcase
      end
      // rows of the previous tick may leave on the edge that takes the next tick
      if (out_mon.valid && out_mon.ready) check_row_word();
      if (in_mon.valid && in_mon.ready) begin
        ticks_seen++;
        predict_tick(in_mon.tilt_sample, in_mon.restart);
      end
      rows_outstanding = expected_rows.size();
    end
  end

endmodule

[verif/hourglass_sand_grid_step_test.sv]
// top of the hourglass sand grid testbench: clock, reset, tick and config stimulus,
// random receiver stalls and the verdict; depends on hsg_pkg, hsg_if, the block
// and hourglass_grid_checker

module hourglass_sand_grid_step_test import hsg_pkg::*; ();

  logic clk;
  logic rst_n;

  hsg_in_if  in_ch ();
  hsg_out_if out_ch ();
  hsg_cfg_if cfg_ch ();

  int mismatch_count;
  int rows_outstanding;

  // thresholds as last written, so tilt samples can aim at the boundaries
  logic [SAMPLE_W-1:0] down_thr_now;
  logic [SAMPLE_W-1:0] up_thr_now;

  // idling knobs, switched per phase
  bit src_gaps;
  bit sink_stalls;
  int stall_left;

  hourglass_sand_grid_step i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  hourglass_grid_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_mon           (in_ch),
    .out_mon          (out_ch),
    .cfg_mon          (cfg_ch),
    .mismatch_count   (mismatch_count),
    .rows_outstanding (rows_outstanding)
  );

  always #5 clk = ~clk;

  // receiver: ready drops in random bursts while stalls are enabled
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // one tick word; valid stays high afterwards unless a gap follows,
  // so back-to-back ticks never lower and raise valid in the same step
  task automatic send_tick(input logic [SAMPLE_W-1:0] tilt, input logic restart);
    in_ch.valid       <= 1'b1;
    in_ch.tilt_sample <= tilt;
    in_ch.restart     <= restart;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // hold off the sender until every row word is back, then let the block settle
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (rows_outstanding != 0);
    repeat (16) @(posedge clk);
  endtask

  // both registers in one burst, valid held across the two words
  task automatic set_thresholds(input logic [SAMPLE_W-1:0] dthr,
                                input logic [SAMPLE_W-1:0] uthr);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_DOWN_THR;
    cfg_ch.data  <= dthr;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= REG_UP_THR;
    cfg_ch.data  <= uthr;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    down_thr_now = dthr;
    up_thr_now   = uthr;
    @(posedge clk);
  endtask

  // mostly uniform, with a share of rail values and samples on the thresholds
  function automatic logic [SAMPLE_W-1:0] pick_tilt();
    int v;
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = 1023;
      2:       v = int'(down_thr_now) + $urandom_range(0, 1);
      3:       v = int'(up_thr_now) - $urandom_range(0, 1);
      default: v = $urandom_range(0, 1023);
    endcase
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_W-1:0];
  endfunction

  // runs of one tilt so the sand really flows through the neck, in half the runs
  // opened by a refill; about one word in six is noise with a rare restart
  task automatic run_phase(input int n_items, input logic [SAMPLE_W-1:0] dthr,
                           input logic [SAMPLE_W-1:0] uthr, input bit idling);
    int                  left;
    int                  run_len;
    int                  i;
    bit                  refill_first;
    logic [SAMPLE_W-1:0] base;
    wait_drain();
    set_thresholds(dthr, uthr);
    src_gaps    = idling;
    sink_stalls = idling;
    left = n_items;
    while (left > 0) begin
      base         = pick_tilt();
      run_len      = $urandom_range(3, 25);
      refill_first = ($urandom_range(0, 1) == 0);
      for (i = 0; i < run_len && left > 0; i++) begin
        if ($urandom_range(0, 5) == 0)
          send_tick(pick_tilt(), $urandom_range(0, 9) == 0);
        else
          send_tick(base, i == 0 && refill_first);
        left--;
      end
    end
  endtask

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.tilt_sample = '0;
    in_ch.restart     = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_DOWN_THR;
    cfg_ch.data       = '0;
    out_ch.ready      = 1'b0;
    stall_left        = 0;
    down_thr_now      = DOWN_THR_RST;
    up_thr_now        = UP_THR_RST;
    src_gaps          = 1'b1;
    sink_stalls       = 1'b1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset thresholds
    send_tick(10'd1023, 1'b1);            // refill for down, top bulb full
    repeat (5) send_tick(10'd536, 1'b0);  // just above down threshold
    send_tick(10'd535, 1'b0);             // on the down threshold: flat, no moves
    send_tick(10'd380, 1'b0);             // on the up threshold: flat
    wait_drain();                         // sender waits for every row word
    send_tick(10'd379, 1'b0);             // just below up threshold, sand climbs back
    send_tick(10'd0, 1'b1);               // refill for up, bottom bulb full
    repeat (4) send_tick(10'd0, 1'b0);
    send_tick(10'd450, 1'b1);             // restart while flat leaves the grid empty
    send_tick(10'd450, 1'b0);             // flat tick on the empty grid
    send_tick(10'd1023, 1'b0);            // pass over an empty grid
    send_tick(10'd1023, 1'b1);
    repeat (3) send_tick(10'd700, 1'b0);

    // random phases over several threshold settings
    run_phase(110, 10'd535, 10'd380, 1'b1);
    run_phase(35, 10'd0, 10'd1023, 1'b1);      // crossed: down wins, only 0 is up
    run_phase(25, 10'd1023, 10'd0, 1'b1);      // nothing can be down or up
    run_phase(40, 10'd1023, 10'd1023, 1'b0);   // up except at full scale
    run_phase(40, 10'd0, 10'd0, 1'b1);         // down except at zero
    run_phase(80, 10'($urandom_range(300, 1023)), 10'($urandom_range(0, 700)), 1'b1);
    run_phase(110, 10'd535, 10'd380, 1'b0);    // closing stretch with no idling

    wait_drain();
    if (mismatch_count == 0 && rows_outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit, several times the slowest legal run
  initial begin
    #(64'd10_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
